>>> src/spdc_pkg.sv
// Shared types, constants and functions for the serial packet deframer.
`default_nettype none
package spdc_pkg;

	localparam int unsigned SYNC_LEN = 12;
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;
	localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

	typedef enum logic [2:0] {
		EV_PAYLOAD = 3'd0,
		EV_GOOD    = 3'd1,
		EV_BAD_CRC = 3'd2,
		EV_TOO_BIG = 3'd3,
		EV_SYNC    = 3'd4
	} event_kind_t;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  frame_type;
		logic [15:0] frame_length;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic [7:0]  computed_crc;
	} result_t;

	typedef struct packed {
		logic [1:0] level;
	} fifo_status_t;

	// Byte of the resync pattern at a given position.
	function automatic logic [7:0] sync_byte(input logic [3:0] pos);
		logic [7:0] b;
		case (pos)
			4'd0:    b = 8'haa;
			4'd1:    b = 8'h08;
			4'd2:    b = 8'h00;
			4'd9:    b = 8'h12;
			4'd10:   b = 8'hab;
			4'd11:   b = 8'hd6;
			default: b = 8'hff;
		endcase
		return b;
	endfunction

	// One byte of CRC-8, MSB first, no reflection.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> src/spdc_core.sv
// Receive state machine: resync hunt, header, payload with CRC, checksum check.
`default_nettype none
module spdc_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      rx_byte,
	input  wire logic            line_error,
	input  wire logic [15:0]     max_len,
	output logic                 res_valid,
	output spdc_pkg::result_t    res
);
	import spdc_pkg::*;

	typedef enum logic [1:0] {
		MODE_RESYNC   = 2'd0,
		MODE_HEADER   = 2'd1,
		MODE_PAYLOAD  = 2'd2,
		MODE_CHECKSUM = 2'd3
	} mode_t;

	localparam logic [3:0] SYNC_LAST = 4'(SYNC_LEN - 1);

	mode_t       mode_q, mode_d;
	logic [3:0]  sync_cnt_q, sync_cnt_d, sync_pos;
	logic [1:0]  hdr_seen_q, hdr_seen_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] len_q, len_d, len_full;
	logic [15:0] remain_q, remain_d;
	logic [7:0]  crc_q, crc_d;

	assign sync_pos = (sync_cnt_q >= 4'(SYNC_LEN)) ? 4'd0 : sync_cnt_q;
	assign len_full = {rx_byte, len_q[7:0]};

	always_comb begin
		mode_d     = mode_q;
		sync_cnt_d = sync_cnt_q;
		hdr_seen_d = hdr_seen_q;
		type_d     = type_q;
		len_d      = len_q;
		remain_d   = remain_q;
		crc_d      = crc_q;
		res_valid  = 1'b0;
		res.kind          = EV_PAYLOAD;
		res.payload_byte  = 8'h00;
		res.payload_index = 16'h0000;
		res.computed_crc  = 8'h00;
		if (accept) begin
			if (line_error) begin
				// A line error always drops back to the hunt without a result.
				mode_d     = MODE_RESYNC;
				sync_cnt_d = 4'd0;
			end else begin
				case (mode_q)
					MODE_RESYNC: begin
						if (rx_byte == sync_byte(sync_pos)) begin
							if (sync_pos == SYNC_LAST) begin
								sync_cnt_d = 4'd0;
								mode_d     = MODE_HEADER;
								hdr_seen_d = 2'd0;
								res_valid  = 1'b1;
								res.kind   = EV_SYNC;
							end else begin
								sync_cnt_d = sync_pos + 4'd1;
							end
						end else begin
							sync_cnt_d = 4'd0;
						end
					end
					MODE_HEADER: begin
						case (hdr_seen_q)
							2'd0: begin
								type_d     = rx_byte;
								hdr_seen_d = 2'd1;
							end
							2'd1: begin
								len_d      = {8'h00, rx_byte};
								hdr_seen_d = 2'd2;
							end
							default: begin
								len_d      = len_full;
								hdr_seen_d = 2'd0;
								if (len_full > max_len) begin
									mode_d     = MODE_RESYNC;
									sync_cnt_d = 4'd0;
									res_valid  = 1'b1;
									res.kind   = EV_TOO_BIG;
								end else begin
									remain_d = len_full;
									crc_d    = CRC_INIT;
									mode_d   = (len_full == 16'd0) ? MODE_CHECKSUM
									                               : MODE_PAYLOAD;
								end
							end
						endcase
					end
					MODE_PAYLOAD: begin
						if (remain_q == 16'd0) begin
							mode_d = MODE_CHECKSUM;
						end else begin
							crc_d             = crc8_byte(crc_q, rx_byte);
							remain_d          = remain_q - 16'd1;
							if (remain_q == 16'd1) begin
								mode_d = MODE_CHECKSUM;
							end
							res_valid         = 1'b1;
							res.kind          = EV_PAYLOAD;
							res.payload_byte  = rx_byte;
							res.payload_index = len_q - remain_q;
						end
					end
					default: begin
						res_valid        = 1'b1;
						res.computed_crc = crc_q;
						if (rx_byte != crc_q) begin
							mode_d     = MODE_RESYNC;
							sync_cnt_d = 4'd0;
							res.kind   = EV_BAD_CRC;
						end else begin
							mode_d     = MODE_HEADER;
							hdr_seen_d = 2'd0;
							res.kind   = EV_GOOD;
						end
					end
				endcase
			end
		end
		// Results carry the header values as they stand after this beat.
		res.frame_type   = type_d;
		res.frame_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RESYNC;
			sync_cnt_q <= 4'd0;
			hdr_seen_q <= 2'd0;
			type_q     <= 8'h00;
			len_q      <= 16'h0000;
			remain_q   <= 16'h0000;
			crc_q      <= CRC_INIT;
		end else begin
			mode_q     <= mode_d;
			sync_cnt_q <= sync_cnt_d;
			hdr_seen_q <= hdr_seen_d;
			type_q     <= type_d;
			len_q      <= len_d;
			remain_q   <= remain_d;
			crc_q      <= crc_d;
		end
	end

endmodule
`default_nettype wire

>>> src/spdc_out_fifo.sv
// Two-entry result queue that decouples the output stall from the input side.
`default_nettype none
module spdc_out_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire spdc_pkg::result_t  push_data,
	input  wire logic               pop,
	output logic                    valid,
	output spdc_pkg::result_t       data,
	output spdc_pkg::fifo_status_t  status
);
	import spdc_pkg::*;

	result_t    entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;

	assign valid        = (level_q != 2'd0);
	assign data         = entries_q[rd_ptr_q];
	assign status.level = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			level_q <= level_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

>>> src/serial_packet_deframer_crc8.sv
// Top level of the serial packet deframer with CRC-8 frame check.
`default_nettype none
// Usage:
// The input channel carries one received byte per beat together with a line
// error flag; a beat is taken when in_valid is high and in_stall is low.
// The block hunts for the 12-byte resync pattern, then reads frames made of a
// type byte, a little-endian 16-bit length, the payload and a CRC-8 byte.
// The output channel delivers at most one result per input beat: payload
// bytes as they arrive, frame good, checksum bad, length too big, or sync.
// One input beat per cycle while in_stall is low; the state update and the
// byte-wide CRC step finish in the cycle the beat is taken. With the queue
// empty, a result shows on the output in the cycle after its input beat.
// Results land in a two-entry queue, so input beats keep flowing while one
// result waits; in_stall rises only when both entries are occupied, which
// happens when the receiver holds out_stall high.
// The maximum payload length register is written through cfg_wr_en and
// cfg_wr_data and resets to 8192; the user must write it only while the block
// is idle, which the block itself does not enforce. Reset puts the receiver
// back into the hunt with all counters cleared and empties the result queue.
module serial_packet_deframer_crc8 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        line_error,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_kind,
	output logic [7:0]       frame_type,
	output logic [15:0]      frame_length,
	output logic [7:0]       payload_byte,
	output logic [15:0]      payload_index,
	output logic [7:0]       computed_crc,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);
	import spdc_pkg::*;

	logic         in_accept;
	logic         out_pop;
	logic         core_valid;
	result_t      core_res;
	result_t      head_res;
	fifo_status_t fifo_status;
	logic [15:0]  max_len_q;

	// The stall comes straight from the queue level, never from out_stall.
	assign in_stall  = (fifo_status.level == 2'd2);
	assign in_accept = in_valid && !in_stall;
	assign out_pop   = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	spdc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.rx_byte    (rx_byte),
		.line_error (line_error),
		.max_len    (max_len_q),
		.res_valid  (core_valid),
		.res        (core_res)
	);

	spdc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (core_valid),
		.push_data (core_res),
		.pop       (out_pop),
		.valid     (out_valid),
		.data      (head_res),
		.status    (fifo_status)
	);

	assign event_kind    = head_res.kind;
	assign frame_type    = head_res.frame_type;
	assign frame_length  = head_res.frame_length;
	assign payload_byte  = head_res.payload_byte;
	assign payload_index = head_res.payload_index;
	assign computed_crc  = head_res.computed_crc;

	// The queue never holds more than its two entries.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_status.level != 2'd3)
		else $error("result queue level out of range");

	// Level tracks pushes and pops exactly.
	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> fifo_status.level == $past(fifo_status.level)
			+ {1'b0, $past(core_valid)} - {1'b0, $past(out_pop)})
		else $error("result queue level mismatch");

	// A result is only produced by an accepted beat.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		core_valid |-> in_accept)
		else $error("result without an accepted input beat");

	// A beat flagged with a line error never yields a result.
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && line_error |-> !core_valid)
		else $error("result produced for a line error beat");

endmodule
`default_nettype wire

>>> dv/deframer_checker.sv
// Checker for the serial packet deframer: predicts each result beat and compares it.
`timescale 1ns / 1ps
module deframer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        line_error,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  event_kind,
	input  logic [7:0]  frame_type,
	input  logic [15:0] frame_length,
	input  logic [7:0]  payload_byte,
	input  logic [15:0] payload_index,
	input  logic [7:0]  computed_crc,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output int          error_count,
	output int          results_pending
);
	import spdc_pkg::*;

	typedef enum logic [1:0] {
		LINK_HUNT,
		LINK_HEADER,
		LINK_BODY,
		LINK_CHECK
	} link_mode_t;

	// Resync pattern, first byte in the top bits.
	localparam logic [95:0] RESYNC_WORD = 96'haa_08_00_ff_ff_ff_ff_ff_ff_12_ab_d6;
	localparam int REPORT_LIMIT = 40;

	link_mode_t  mode;
	logic [3:0]  match_pos;
	logic [1:0]  hdr_pos;
	logic [7:0]  cur_type;
	logic [15:0] cur_len;
	logic [15:0] left;
	logic [7:0]  crc;
	logic [15:0] max_len;
	result_t     expected_events[$];

	initial begin
		error_count = 0;
		results_pending = 0;
	end

	// Bit-serial CRC-8, data fed MSB first into the feedback.
	function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] c;
		logic fb;
		c = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[7] ^ d[k];
			c = {c[6:0], 1'b0};
			if (fb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic result_t frame_event(input event_kind_t k, input logic [7:0] pb,
			input logic [15:0] pi, input logic [7:0] c);
		result_t r;
		r.kind = k;
		r.frame_type = cur_type;
		r.frame_length = cur_len;
		r.payload_byte = pb;
		r.payload_index = pi;
		r.computed_crc = c;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (error_count < REPORT_LIMIT)
			$display("%0t deframer: %s got 0x%0h, want 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Advances the predicted receiver by one byte.
	task automatic deframe_byte(input logic [7:0] b, input logic err, output bit produced,
			output result_t ev);
		int top_bit;
		logic [15:0] idx;
		produced = 1'b0;
		ev = '0;
		case (mode)
			LINK_HUNT: begin
				if (err) begin
					match_pos = 4'd0;
				end else begin
					if (match_pos >= SYNC_LEN) match_pos = 4'd0;
					top_bit = 95 - 8 * int'(match_pos);
					if (b == RESYNC_WORD[top_bit -: 8]) begin
						match_pos++;
						if (match_pos == SYNC_LEN) begin
							match_pos = 4'd0;
							mode = LINK_HEADER;
							hdr_pos = 2'd0;
							produced = 1'b1;
							ev = frame_event(EV_SYNC, 8'd0, 16'd0, 8'd0);
						end
					end else begin
						match_pos = 4'd0;
					end
				end
			end
			LINK_HEADER: begin
				if (err) begin
					mode = LINK_HUNT;
					match_pos = 4'd0;
				end else if (hdr_pos == 2'd0) begin
					cur_type = b;
					hdr_pos = 2'd1;
				end else if (hdr_pos == 2'd1) begin
					cur_len = {8'd0, b};
					hdr_pos = 2'd2;
				end else begin
					// Last header byte; an out-of-range count lands here as well.
					cur_len = {b, cur_len[7:0]};
					hdr_pos = 2'd0;
					if (cur_len > max_len) begin
						mode = LINK_HUNT;
						match_pos = 4'd0;
						produced = 1'b1;
						ev = frame_event(EV_TOO_BIG, 8'd0, 16'd0, 8'd0);
					end else begin
						left = cur_len;
						crc = CRC_INIT;
						mode = (cur_len == 16'd0) ? LINK_CHECK : LINK_BODY;
					end
				end
			end
			LINK_BODY: begin
				if (err) begin
					mode = LINK_HUNT;
					match_pos = 4'd0;
				end else if (left == 16'd0) begin
					mode = LINK_CHECK;
				end else begin
					idx = cur_len - left;
					crc = crc_next(crc, b);
					left--;
					if (left == 16'd0) mode = LINK_CHECK;
					produced = 1'b1;
					ev = frame_event(EV_PAYLOAD, b, idx, 8'd0);
				end
			end
			default: begin
				if (err) begin
					mode = LINK_HUNT;
					match_pos = 4'd0;
				end else if (b != crc) begin
					mode = LINK_HUNT;
					match_pos = 4'd0;
					produced = 1'b1;
					ev = frame_event(EV_BAD_CRC, 8'd0, 16'd0, crc);
				end else begin
					mode = LINK_HEADER;
					hdr_pos = 2'd0;
					produced = 1'b1;
					ev = frame_event(EV_GOOD, 8'd0, 16'd0, crc);
				end
			end
		endcase
	endtask

	task automatic check_result();
		result_t want;
		if (expected_events.size() == 0) begin
			report_mismatch("result with nothing outstanding, event_kind",
				16'(event_kind), 16'd0);
			return;
		end
		want = expected_events.pop_front();
		if (event_kind !== want.kind)
			report_mismatch("event_kind", 16'(event_kind), 16'(want.kind));
		if (frame_type !== want.frame_type)
			report_mismatch("frame_type", 16'(frame_type), 16'(want.frame_type));
		if (frame_length !== want.frame_length)
			report_mismatch("frame_length", frame_length, want.frame_length);
		if (payload_byte !== want.payload_byte)
			report_mismatch("payload_byte", 16'(payload_byte), 16'(want.payload_byte));
		if (payload_index !== want.payload_index)
			report_mismatch("payload_index", payload_index, want.payload_index);
		if (computed_crc !== want.computed_crc)
			report_mismatch("computed_crc", 16'(computed_crc), 16'(want.computed_crc));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		bit produced;
		result_t ev;
		if (!arst_n) begin
			mode = LINK_HUNT;
			match_pos = 4'd0;
			hdr_pos = 2'd0;
			cur_type = 8'd0;
			cur_len = 16'd0;
			left = 16'd0;
			crc = CRC_INIT;
			max_len = MAX_LEN_RESET;
			expected_events.delete();
			results_pending = 0;
		end else begin
			// A result can never belong to the byte taken at the same edge,
			// so the output side is checked before the new prediction is queued.
			if (out_valid === 1'b1 && out_stall === 1'b0) check_result();
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				deframe_byte(rx_byte, line_error, produced, ev);
				if (produced) expected_events.push_back(ev);
			end
			if (cfg_wr_en === 1'b1) max_len = cfg_wr_data;
			results_pending = expected_events.size();
		end
	end

endmodule

>>> dv/tb_top.sv
// Testbench top for the serial packet deframer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;
	import spdc_pkg::*;

	// How a generated frame is meant to end. Anything but a good ending
	// drops the receiver back into the resync hunt.
	typedef enum int {
		END_GOOD,
		END_BAD_CRC,
		END_ERR_HEADER,
		END_ERR_BODY,
		END_ERR_CHECK
	} frame_end_t;

	// Stall patterns of the result receiver; each one lasts a random span.
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_pattern_t;

	localparam int LONG_HOLD = 80;     // cycles of the forced receiver hold-off
	localparam int DRAIN_TAIL = 8;     // latency margin once no result is owed
	localparam int DRAIN_LIMIT = 4000; // cycles allowed for outstanding results
	localparam int PHASE_BEATS = 40;   // random beats per register setting
	localparam int LONG_FRAME = 300;   // one full frame with a nonzero length high byte

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        line_error;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  event_kind;
	logic [7:0]  frame_type;
	logic [15:0] frame_length;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [7:0]  computed_crc;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	int          check_errors;
	int          results_pending;

	// Stimulus bookkeeping. The top keeps its own copy of the length limit
	// only to know whether a header will be accepted; prediction lives in
	// the checker.
	logic [15:0] cur_max;
	int          beats_sent;
	int          burst_left;
	int          hold_requests;

	serial_packet_deframer_crc8 dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.line_error   (line_error),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.computed_crc (computed_crc),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	deframer_checker frame_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.line_error     (line_error),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_kind     (event_kind),
		.frame_type     (frame_type),
		.frame_length   (frame_length),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.computed_crc   (computed_crc),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.error_count    (check_errors),
		.results_pending(results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one beat and returns at the edge that takes it. The sender runs
	// in bursts: when a burst is used up, valid drops for a random gap (often
	// none at all) and a new burst length is drawn. Valid is only lowered at
	// the start of a gap, so it is never lowered and raised in one step.
	task automatic offer_byte(input logic [7:0] b, input logic err);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		line_error <= err;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		burst_left--;
		beats_sent++;
	endtask

	task automatic offer_resync();
		for (int k = 0; k < SYNC_LEN; k++) offer_byte(sync_byte(4'(k)), 1'b0);
	endtask

	// Sends one frame header, payload and checksum, ending as asked. Frames
	// longer than 320 bytes that pass the limit are cut short by a line error
	// within the first six payload bytes, so the largest lengths stay cheap.
	// The flag tells whether the receiver is expected to be waiting for the
	// next header afterwards.
	task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
			input frame_end_t how, output bit synced);
		logic [7:0] head [3];
		logic [7:0] crc;
		logic [7:0] b;
		int cut;
		head[0] = ftype;
		head[1] = flen[7:0];
		head[2] = flen[15:8];
		synced = 1'b0;
		if (flen > 16'd320) how = END_ERR_BODY;
		if (how == END_ERR_BODY && flen == 16'd0) how = END_ERR_CHECK;
		cut = (how == END_ERR_HEADER) ? $urandom_range(0, 2) : -1;
		for (int k = 0; k < 3; k++) begin
			if (k == cut) begin
				offer_byte(8'($urandom), 1'b1);
				return;
			end
			offer_byte(head[k], 1'b0);
		end
		// A length over the limit ends the frame right at the header.
		if (flen > cur_max) return;
		cut = (how == END_ERR_BODY) ?
			$urandom_range(0, (flen > 16'd320) ? 5 : int'(flen) - 1) : -1;
		crc = CRC_INIT;
		for (int k = 0; k < int'(flen); k++) begin
			if (k == cut) begin
				offer_byte(8'($urandom), 1'b1);
				return;
			end
			b = 8'($urandom);
			offer_byte(b, 1'b0);
			crc = crc8_byte(crc, b);
		end
		case (how)
			END_ERR_CHECK: offer_byte(8'($urandom), 1'b1);
			END_BAD_CRC:   offer_byte(crc ^ 8'($urandom_range(1, 255)), 1'b0);
			default: begin
				offer_byte(crc, 1'b0);
				synced = 1'b1;
			end
		endcase
	endtask

	// Stops offering and waits until every predicted result has been taken,
	// then lets a few more cycles pass for bytes that produce no result.
	task automatic drain_results();
		int waited;
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		waited = 0;
		while (results_pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Result receiver. It switches between stall patterns at random spans,
	// free running among them. When the stimulus asks for a hold-off, it
	// keeps out_stall high for a long counted stretch while the sender keeps
	// offering beats, so the result queue fills and the block stalls its input.
	initial begin : receiver
		rx_pattern_t pattern;
		int span;
		int holds_done;
		out_stall = 1'b0;
		pattern = RX_FREE;
		span = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done < hold_requests) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (span == 0) begin
				pattern = rx_pattern_t'($urandom_range(0, 3));
				span = $urandom_range(16, 120);
			end
			span--;
			case (pattern)
				RX_FREE:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:  out_stall <= ~out_stall;
			endcase
		end
	end

	initial begin : stimulus
		bit synced;
		int target;
		int nframes;
		int nbytes;
		int sel;
		logic [15:0] flen;
		logic [15:0] new_max;
		frame_end_t how;

		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		line_error = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 16'd0;
		cur_max = MAX_LEN_RESET;
		beats_sent = 0;
		burst_left = 0;
		hold_requests = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the limit at its reset value.
		// A line error in the middle of the hunt clears the partial match.
		offer_byte(8'haa, 1'b0);
		offer_byte(8'h08, 1'b0);
		offer_byte(8'h5c, 1'b1);
		// A mismatching byte restarts the match without being tested again:
		// the second aa here does not count as a new first pattern byte.
		offer_byte(8'haa, 1'b0);
		offer_byte(8'h08, 1'b0);
		offer_byte(8'haa, 1'b0);
		offer_resync();
		// Zero length goes straight to the checksum byte, then a short good
		// frame and one with a wrong checksum.
		send_frame(8'hff, 16'd0, END_GOOD, synced);
		send_frame(8'h00, 16'd3, END_GOOD, synced);
		send_frame(8'h5a, 16'd2, END_BAD_CRC, synced);
		// One past the limit is refused; exactly the limit is accepted and
		// then broken off by a line error in the payload.
		offer_resync();
		send_frame(8'ha5, MAX_LEN_RESET + 16'd1, END_GOOD, synced);
		offer_resync();
		send_frame(8'h3c, MAX_LEN_RESET, END_ERR_BODY, synced);
		// Line errors in the header and on the checksum byte.
		offer_resync();
		send_frame(8'h11, 16'd4, END_ERR_HEADER, synced);
		offer_resync();
		send_frame(8'h22, 16'd1, END_ERR_CHECK, synced);

		// Random part, one phase per setting of the length limit: the reset
		// value, both extremes, a small random limit and a mid-size one.
		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				case (phase)
					1:       new_max = 16'd0;
					2:       new_max = 16'hffff;
					3:       new_max = 16'($urandom_range(1, 40));
					default: new_max = 16'(LONG_FRAME);
				endcase
				drain_results();
				cfg_wr_en <= 1'b1;
				cfg_wr_data <= new_max;
				cur_max = new_max;
				@(posedge clk);
				cfg_wr_en <= 1'b0;
			end
			if (phase == 0) hold_requests++;
			if (phase == 2) begin
				// The largest length is accepted here; it is cut short early.
				offer_resync();
				send_frame(8'hff, 16'hffff, END_GOOD, synced);
			end
			if (phase == 4) begin
				// A full long frame under a receiver hold-off.
				offer_resync();
				hold_requests++;
				send_frame(8'($urandom), 16'(LONG_FRAME), END_GOOD, synced);
			end
			target = beats_sent + PHASE_BEATS;
			while (beats_sent < target) begin
				if ($urandom_range(0, 4) != 0) begin
					// Well-formed: a little line noise, the resync pattern,
					// then up to five frames, stopping early when one breaks the link.
					repeat ($urandom_range(0, 2)) offer_byte(8'($urandom), 1'b0);
					offer_resync();
					nframes = $urandom_range(1, 5);
					synced = 1'b1;
					for (int f = 0; f < nframes && synced; f++) begin
						sel = $urandom_range(0, 19);
						if (sel == 0)
							flen = 16'd0;
						else if (sel == 1)
							flen = cur_max;
						else if (sel == 2)
							flen = (cur_max == 16'hffff) ? cur_max : cur_max + 16'd1;
						else if (sel == 3)
							flen = 16'($urandom);
						else if (cur_max < 16'd24)
							flen = 16'($urandom_range(0, cur_max));
						else
							flen = 16'($urandom_range(1, 24));
						sel = $urandom_range(0, 19);
						how = (sel == 0) ? END_ERR_HEADER :
							(sel == 1) ? END_ERR_BODY :
							(sel == 2) ? END_ERR_CHECK :
							(sel < 5) ? END_BAD_CRC : END_GOOD;
						send_frame(8'($urandom), flen, how, synced);
					end
				end else begin
					// Noise: pieces of the pattern in and out of place,
					// random bytes and line errors.
					nbytes = $urandom_range(1, 12);
					for (int k = 0; k < nbytes; k++) begin
						case ($urandom_range(0, 3))
							0: offer_byte(sync_byte(4'(k)), 1'b0);
							1: offer_byte(sync_byte(4'($urandom_range(0, 11))), 1'b0);
							2: offer_byte(8'($urandom), 1'b0);
							default: offer_byte(8'($urandom), 1'b1);
						endcase
					end
				end
			end
		end

		drain_results();
		if (check_errors == 0 && results_pending == 0) begin
			$display("[serial_packet_deframer_crc8] OK");
		end else begin
			$display("[serial_packet_deframer_crc8] ERROR");
		end
		$finish;
	end

	// Watchdog: a correct run ends far sooner than this.
	initial begin
		#5_000_000;
		$display("[serial_packet_deframer_crc8] ERROR");
		$finish;
	end

endmodule
